/* sv/tpp_pkg.sv */
// shared constants, codes and saturating helpers for the trapezoidal position profiler
package tpp_pkg;

   // word format, signed q8.24
   localparam int WORD_WIDTH    = 32;
   localparam int FRACTION_BITS = 24;
   localparam int REG_WIDTH     = WORD_WIDTH - 1;
   localparam int PROD_WIDTH    = 2 * WORD_WIDTH;

   // elapsed time after clamping fits in this many bits
   localparam int DT_WIDTH      = 20;
   // a*dt and |v|*dt after the fraction shift fit in this many bits
   localparam int STEP_WIDTH    = 27;
   localparam int STEP_TOP      = FRACTION_BITS + STEP_WIDTH - 1;
   localparam int STEP_COUNT_WIDTH = 7;

   localparam logic [DT_WIDTH-1:0]   DT_MAX      = DT_WIDTH'(838861);
   localparam logic [WORD_WIDTH-1:0] SNAP_LIMIT  = WORD_WIDTH'(838861);
   localparam logic [WORD_WIDTH-1:0] HOME_STEP   = WORD_WIDTH'(83886);
   localparam logic [REG_WIDTH-1:0]  ACCEL_EPS   = REG_WIDTH'(17);
   localparam logic [STEP_COUNT_WIDTH-1:0] HOME_STEP_LIMIT = STEP_COUNT_WIDTH'(100);

   localparam logic [REG_WIDTH-1:0]  ACCEL_RESET     = REG_WIDTH'(16777216);
   localparam logic [REG_WIDTH-1:0]  MAX_SPEED_RESET = REG_WIDTH'(8388608);

   localparam logic [WORD_WIDTH-1:0] SMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] SMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   // register indexes on the csr port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCELERATION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_SPEED    = 2'd1;

   // request commands
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_HOME = 1'b1;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] op_a;
      logic [WORD_WIDTH-1:0] op_b;
   } tpp_mul_req_type;

   function automatic logic [WORD_WIDTH-1:0] sat_add(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b);
      logic [WORD_WIDTH:0] sum;
      sum = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
      if (sum[WORD_WIDTH] != sum[WORD_WIDTH-1]) begin
         sat_add = sum[WORD_WIDTH] ? SMIN : SMAX;
      end else begin
         sat_add = sum[WORD_WIDTH-1:0];
      end
   endfunction

   function automatic logic [WORD_WIDTH-1:0] sat_sub(input logic [WORD_WIDTH-1:0] a,
                                                     input logic [WORD_WIDTH-1:0] b);
      logic [WORD_WIDTH:0] diff;
      diff = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
      if (diff[WORD_WIDTH] != diff[WORD_WIDTH-1]) begin
         sat_sub = diff[WORD_WIDTH] ? SMIN : SMAX;
      end else begin
         sat_sub = diff[WORD_WIDTH-1:0];
      end
   endfunction

   // unsigned magnitude of a signed word, the most negative value maps to 2^(w-1)
   function automatic logic [WORD_WIDTH-1:0] magnitude(input logic [WORD_WIDTH-1:0] a);
      magnitude = a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
   endfunction

endpackage

/* sv/tpp_mul.sv */
// shared unsigned multiplier with registered product
module tpp_mul (
   input  logic                          clock,
   input  tpp_pkg::tpp_mul_req_type      mul_req,
   output logic [tpp_pkg::PROD_WIDTH-1:0] product
);
   import tpp_pkg::*;

   logic [PROD_WIDTH-1:0] product_ff;
   logic [PROD_WIDTH-1:0] product_in;

   assign product_in = PROD_WIDTH'(mul_req.op_a) * PROD_WIDTH'(mul_req.op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

/* sv/trapezoidal_position_profiler_top.sv */
// trapezoidal position profiler with homing sequence, top level
// a profile tick makes four passes through the one shared 32x32 multiplier, then updates velocity
// and position; a homing tick makes one homing step and a home command goes straight to the response
// register; the next request is taken in the cycle after the response is loaded
// reset (synchronous, active high) clears position, velocity, homing state and the response valid flag,
// and loads acceleration 1.0 and max speed 0.5
module trapezoidal_position_profiler_top (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [tpp_pkg::REG_WIDTH-1:0]     req_elapsed_time,
   input  logic signed [tpp_pkg::WORD_WIDTH-1:0] req_target_position,
   input  logic signed [tpp_pkg::WORD_WIDTH-1:0] req_measured_position,
   input  logic                              req_reverse_limit,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tpp_pkg::WORD_WIDTH-1:0] rsp_commanded_position,
   output logic signed [tpp_pkg::WORD_WIDTH-1:0] rsp_profile_velocity,
   output logic                              rsp_homing_active,
   output logic                              rsp_sensor_reset,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tpp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tpp_pkg::REG_WIDTH-1:0]     csr_data
);
   import tpp_pkg::*;

   // one-hot sequencer states
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_HOME   = 10'b0000000010,
      ST_AD     = 10'b0000000100,   // issue a*dt
      ST_AE     = 10'b0000001000,   // take a*dt, issue a*|e|
      ST_SS     = 10'b0000010000,   // take a*|e|, issue s*s
      ST_CMP    = 10'b0000100000,   // stopping test
      ST_VEL    = 10'b0001000000,   // next velocity
      ST_PV     = 10'b0010000000,   // issue |v|*dt
      ST_POS    = 10'b0100000000,   // integrate position
      ST_FINISH = 10'b1000000000    // hand over to the response register
   } tpp_state_type;

   tpp_state_type state_ff, state_in;

   // configuration registers
   logic [REG_WIDTH-1:0] accel_ff, accel_in;
   logic [REG_WIDTH-1:0] max_speed_ff, max_speed_in;

   // architectural state
   logic [WORD_WIDTH-1:0] setpoint_ff, setpoint_in;
   logic [WORD_WIDTH-1:0] velocity_ff, velocity_in;
   logic                  homing_ff, homing_in;
   logic [STEP_COUNT_WIDTH-1:0] steps_ff, steps_in;
   logic                  finished_ff, finished_in;

   // request fields held for the duration of the tick
   logic [DT_WIDTH-1:0]   dt_ff, dt_in;
   logic [WORD_WIDTH-1:0] target_ff, target_in;
   logic [WORD_WIDTH-1:0] measured_ff, measured_in;
   logic                  limit_ff, limit_in;

   // intermediate results between multiplier passes
   logic [WORD_WIDTH-1:0] error_ff, error_in;
   logic [STEP_WIDTH-1:0] ad_ff, ad_in;
   logic [PROD_WIDTH-2:0] pe_ff, pe_in;
   logic                  stop_ff, stop_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_pos_ff, rsp_pos_in;
   logic [WORD_WIDTH-1:0] rsp_vel_ff, rsp_vel_in;
   logic                  rsp_homing_ff, rsp_homing_in;
   logic                  rsp_sreset_ff, rsp_sreset_in;

   tpp_mul_req_type       mul_req;
   logic [PROD_WIDTH-1:0] product;

   logic                  req_fire;
   logic                  rsp_load;
   logic [REG_WIDTH-1:0]  accel_eff;
   logic [WORD_WIDTH-1:0] max_v;
   logic [WORD_WIDTH-1:0] max_v_neg;
   logic [WORD_WIDTH-1:0] ad_word;
   logic [WORD_WIDTH:0]   stop_speed;
   logic [WORD_WIDTH-1:0] v_plus;
   logic [WORD_WIDTH-1:0] v_minus;
   logic [WORD_WIDTH-1:0] v_next;
   logic [STEP_WIDTH-1:0] pv_mag;
   logic [WORD_WIDTH-1:0] pv_word;
   logic [WORD_WIDTH-1:0] home_diff;
   logic [WORD_WIDTH-1:0] home_base;

   tpp_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // zero acceleration stands for one micro unit
   assign accel_eff = (accel_ff == '0) ? ACCEL_EPS : accel_ff;
   assign max_v     = {1'b0, max_speed_ff};
   assign max_v_neg = ~max_v + 1'b1;
   assign ad_word   = WORD_WIDTH'(ad_ff);

   // stopping speed |v| + a*dt stays below 2^32
   assign stop_speed = {1'b0, magnitude(velocity_ff)} + (WORD_WIDTH+1)'(ad_ff);

   assign v_plus  = sat_add(velocity_ff, ad_word);
   assign v_minus = sat_sub(velocity_ff, ad_word);

   // pick the next velocity
   always_comb begin
      if (error_ff[WORD_WIDTH-1]) begin
         // target lies ahead in the positive direction
         priority if (velocity_ff[WORD_WIDTH-1]) begin
            v_next = v_plus;
         end else if (stop_ff) begin
            v_next = v_minus;
         end else begin
            v_next = ($signed(v_plus) > $signed(max_v)) ? max_v : v_plus;
         end
      end else begin
         priority if (!velocity_ff[WORD_WIDTH-1] && (velocity_ff != '0)) begin
            v_next = v_minus;
         end else if (stop_ff) begin
            v_next = v_plus;
         end else begin
            v_next = ($signed(v_minus) < $signed(max_v_neg)) ? max_v_neg : v_minus;
         end
      end
   end

   // position step, truncated toward zero, never saturates at this width
   assign pv_mag  = product[STEP_TOP:FRACTION_BITS];
   assign pv_word = velocity_ff[WORD_WIDTH-1] ? (~WORD_WIDTH'(pv_mag) + 1'b1)
                                              : WORD_WIDTH'(pv_mag);

   // homing: snap to the sensor when too far off, then step down
   assign home_diff = sat_sub(setpoint_ff, measured_ff);
   assign home_base = (magnitude(home_diff) > SNAP_LIMIT) ? measured_ff : setpoint_ff;

   // operand selection for the shared multiplier
   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         ST_AD: begin
            mul_req.op_a = WORD_WIDTH'(accel_eff);
            mul_req.op_b = WORD_WIDTH'(dt_ff);
         end
         ST_AE: begin
            mul_req.op_a = WORD_WIDTH'(accel_eff);
            mul_req.op_b = magnitude(error_ff);
         end
         ST_SS: begin
            mul_req.op_a = stop_speed[WORD_WIDTH-1:0];
            mul_req.op_b = stop_speed[WORD_WIDTH-1:0];
         end
         ST_PV: begin
            mul_req.op_a = magnitude(velocity_ff);
            mul_req.op_b = WORD_WIDTH'(dt_ff);
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   // response register frees as soon as the current response is taken
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      accel_in     = accel_ff;
      max_speed_in = max_speed_ff;
      setpoint_in  = setpoint_ff;
      velocity_in  = velocity_ff;
      homing_in    = homing_ff;
      steps_in     = steps_ff;
      finished_in  = finished_ff;
      dt_in        = dt_ff;
      target_in    = target_ff;
      measured_in  = measured_ff;
      limit_in     = limit_ff;
      error_in     = error_ff;
      ad_in        = ad_ff;
      pe_in        = pe_ff;
      stop_in      = stop_ff;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_homing_in = rsp_homing_ff;
      rsp_sreset_in = rsp_sreset_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ACCELERATION: accel_in     = csr_data;
            CSR_MAX_SPEED:    max_speed_in = csr_data;
            default: begin
               accel_in     = accel_ff;
               max_speed_in = max_speed_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               dt_in       = (req_elapsed_time > REG_WIDTH'(DT_MAX))
                             ? DT_MAX : req_elapsed_time[DT_WIDTH-1:0];
               target_in   = req_target_position;
               measured_in = req_measured_position;
               limit_in    = req_reverse_limit;
               finished_in = 1'b0;
               priority if (req_command == CMD_HOME) begin
                  homing_in = 1'b1;
                  state_in  = ST_FINISH;
               end else if (homing_ff) begin
                  state_in  = ST_HOME;
               end else begin
                  state_in  = ST_AD;
               end
            end
         end
         ST_HOME: begin
            if (limit_ff || (steps_ff > HOME_STEP_LIMIT)) begin
               setpoint_in = '0;
               velocity_in = '0;
               homing_in   = 1'b0;
               steps_in    = '0;
               finished_in = 1'b1;
            end else begin
               setpoint_in = sat_sub(home_base, HOME_STEP);
               steps_in    = steps_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_AD: begin
            error_in = sat_sub(setpoint_ff, target_ff);
            state_in = ST_AE;
         end
         ST_AE: begin
            ad_in    = product[STEP_TOP:FRACTION_BITS];
            state_in = ST_SS;
         end
         ST_SS: begin
            pe_in    = product[PROD_WIDTH-2:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // exact test s*s >= 2*a*|e|
            stop_in  = (product >= {pe_ff, 1'b0});
            state_in = ST_VEL;
         end
         ST_VEL: begin
            velocity_in = v_next;
            state_in    = ST_PV;
         end
         ST_PV: begin
            state_in = ST_POS;
         end
         ST_POS: begin
            setpoint_in = sat_add(setpoint_ff, pv_word);
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = setpoint_ff;
               rsp_vel_in    = velocity_ff;
               rsp_homing_in = homing_ff;
               rsp_sreset_in = finished_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         accel_ff      <= ACCEL_RESET;
         max_speed_ff  <= MAX_SPEED_RESET;
         setpoint_ff   <= '0;
         velocity_ff   <= '0;
         homing_ff     <= 1'b0;
         steps_ff      <= '0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         accel_ff      <= accel_in;
         max_speed_ff  <= max_speed_in;
         setpoint_ff   <= setpoint_in;
         velocity_ff   <= velocity_in;
         homing_ff     <= homing_in;
         steps_ff      <= steps_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      dt_ff         <= dt_in;
      target_ff     <= target_in;
      measured_ff   <= measured_in;
      limit_ff      <= limit_in;
      error_ff      <= error_in;
      ad_ff         <= ad_in;
      pe_ff         <= pe_in;
      stop_ff       <= stop_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_homing_ff <= rsp_homing_in;
      rsp_sreset_ff <= rsp_sreset_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_commanded_position = rsp_pos_ff;
   assign rsp_profile_velocity   = rsp_vel_ff;
   assign rsp_homing_active      = rsp_homing_ff;
   assign rsp_sensor_reset       = rsp_sreset_ff;

endmodule

/* verif/trapezoidal_position_profiler_top_test.sv */
// self-checking testbench for the trapezoidal position profiler top level
module trapezoidal_position_profiler_top_test;

   import tpp_pkg::*;

   localparam int W  = tpp_pkg::WORD_WIDTH;
   localparam int RW = tpp_pkg::REG_WIDTH;
   localparam int IW = tpp_pkg::CSR_INDEX_WIDTH;

   // fixed point constants of the profile, q8.24
   localparam int          FRAC        = 24;
   localparam longint      WORD_HI     = 64'sd2147483647;
   localparam longint      WORD_LO     = -64'sd2147483648;
   localparam logic [63:0] DT_CLAMP    = 64'd838861;   // 0.05 s
   localparam longint      SNAP_DIST   = 64'sd838861;  // 0.05
   localparam longint      HOME_DROP   = 64'sd83886;   // 0.005
   localparam logic [63:0] ACCEL_FLOOR = 64'd17;       // 0.000001
   localparam logic [6:0]  HOME_LIMIT  = 7'd100;

   localparam logic [RW-1:0] ACCEL_AT_RESET = 31'd16777216;
   localparam logic [RW-1:0] VMAX_AT_RESET  = 31'd8388608;
   localparam logic [RW-1:0] REG_TOP        = {RW{1'b1}};

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 60;

   typedef struct {
      logic          command;
      logic [RW-1:0] elapsed;
      logic [W-1:0]  target;
      logic [W-1:0]  measured;
      logic          rev_limit;
   } tick_request_type;

   typedef struct {
      logic [W-1:0] position;
      logic [W-1:0] velocity;
      logic         homing;
      logic         sensor_reset;
   } profile_result_type;

   // ------------------------------------------------------------------
   // dut hookup, every input known from time zero
   // ------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = 1'b0;
   logic [RW-1:0]       req_elapsed_time = '0;
   logic signed [W-1:0] req_target_position = '0;
   logic signed [W-1:0] req_measured_position = '0;
   logic                req_reverse_limit = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_commanded_position;
   logic signed [W-1:0] rsp_profile_velocity;
   logic                rsp_homing_active;
   logic                rsp_sensor_reset;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [IW-1:0]       csr_index = '0;
   logic [RW-1:0]       csr_data = '0;

   trapezoidal_position_profiler_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_elapsed_time       (req_elapsed_time),
      .req_target_position    (req_target_position),
      .req_measured_position  (req_measured_position),
      .req_reverse_limit      (req_reverse_limit),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_commanded_position (rsp_commanded_position),
      .rsp_profile_velocity   (rsp_profile_velocity),
      .rsp_homing_active      (rsp_homing_active),
      .rsp_sensor_reset       (rsp_sensor_reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // 10 unit period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // bookkeeping shared between the processes
   // ------------------------------------------------------------------
   tick_request_type   tick_queue[$];        // requests waiting to be driven
   profile_result_type pending_results[$];   // predicted responses, oldest first
   int                 req_issued = 0;
   int                 req_accepted = 0;
   int                 responses_seen = 0;
   int                 csr_writes = 0;
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 items_generated = 0;
   int                 home_commands = 0;
   int                 homing_completions = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   tick_request_type   drive_item;

   // ------------------------------------------------------------------
   // predictor state: its own copy of position, velocity, homing and registers
   // ------------------------------------------------------------------
   longint        prof_position;
   longint        prof_velocity;
   bit            prof_homing;
   logic [6:0]    prof_steps;
   logic [RW-1:0] acc_reg;
   logic [RW-1:0] vmax_reg;

   function automatic longint word_sat(input longint x);
      if (x > WORD_HI) return WORD_HI;
      if (x < WORD_LO) return WORD_LO;
      return x;
   endfunction

   function automatic longint word_add(input longint a, input longint b);
      return word_sat(a + b);
   endfunction

   function automatic longint word_sub(input longint a, input longint b);
      return word_sat(a - b);
   endfunction

   function automatic logic [63:0] abs_word(input longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   // signed value times unsigned q8.24 factor, truncated toward zero, saturated
   function automatic longint scale_q(input longint x, input logic [63:0] q);
      logic [127:0] prod;
      prod = ({64'd0, abs_word(x)} * {64'd0, q}) >> FRAC;
      if (x < 0) begin
         if (prod >= 128'd2147483648) return WORD_LO;
         return -longint'(prod[31:0]);
      end
      if (prod > 128'd2147483647) return WORD_HI;
      return longint'(prod[31:0]);
   endfunction

   // exact test of s*s >= 2*a*e
   function automatic bit stop_needed(input logic [63:0] s, input logic [63:0] a,
                                      input logic [63:0] e);
      logic [127:0] lhs;
      logic [127:0] rhs;
      lhs = {64'd0, s} * {64'd0, s};
      rhs = ({64'd0, a} * {64'd0, e}) << 1;
      return lhs >= rhs;
   endfunction

   function automatic void run_step(input logic [RW-1:0] elapsed, input longint target);
      logic [63:0] a;
      logic [63:0] dt_q;
      longint      vmax;
      longint      v;
      longint      ad;
      longint      err;
      longint      nv;
      longint      t;
      bit          stop;
      a    = (acc_reg != '0) ? 64'(acc_reg) : ACCEL_FLOOR;
      dt_q = (64'(elapsed) > DT_CLAMP) ? DT_CLAMP : 64'(elapsed);
      vmax = $signed({33'd0, vmax_reg});
      v    = prof_velocity;
      ad   = scale_q($signed(a), dt_q);
      err  = word_sub(prof_position, target);
      stop = stop_needed(abs_word(v) + 64'(ad), a, abs_word(err));
      if (err < 0) begin
         // target lies above
         if (v < 0) begin
            nv = word_add(v, ad);
         end else if (stop) begin
            nv = word_sub(v, ad);
         end else begin
            t  = word_add(v, ad);
            nv = (t > vmax) ? vmax : t;
         end
      end else begin
         if (v > 0) begin
            nv = word_sub(v, ad);
         end else if (stop) begin
            nv = word_add(v, ad);
         end else begin
            t  = word_sub(v, ad);
            nv = (t < -vmax) ? -vmax : t;
         end
      end
      prof_velocity = nv;
      prof_position = word_add(prof_position, scale_q(nv, dt_q));
   endfunction

   // returns 1 on the tick that ends homing
   function automatic bit homing_step(input longint meas, input logic lim);
      if (lim || prof_steps > HOME_LIMIT) begin
         prof_position = 0;
         prof_velocity = 0;
         prof_homing   = 1'b0;
         prof_steps    = '0;
         return 1'b1;
      end
      if (abs_word(word_sub(prof_position, meas)) > 64'(SNAP_DIST)) prof_position = meas;
      prof_position = word_sub(prof_position, HOME_DROP);
      prof_steps    = prof_steps + 7'd1;
      return 1'b0;
   endfunction

   function automatic profile_result_type step_profiler(input tick_request_type rq);
      profile_result_type res;
      bit                 done;
      done = 1'b0;
      if (rq.command == CMD_HOME) begin
         prof_homing = 1'b1;
      end else if (prof_homing) begin
         done = homing_step($signed(rq.measured), rq.rev_limit);
      end else begin
         run_step(rq.elapsed, $signed(rq.target));
      end
      res.position     = prof_position[W-1:0];
      res.velocity     = prof_velocity[W-1:0];
      res.homing       = prof_homing;
      res.sensor_reset = done;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input longint exp_v,
                                         input longint act_v);
      if (mismatch_count < 10) begin
         $display("mismatch on response %0d, %s: expected %0d, got %0d",
                  responses_seen, what, exp_v, act_v);
      end
      mismatch_count++;
   endfunction

   // ------------------------------------------------------------------
   // monitor: sample every handshake at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      profile_result_type want;
      tick_request_type   seen;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         // predictor follows the block out of reset
         prof_position = 0;
         prof_velocity = 0;
         prof_homing   = 1'b0;
         prof_steps    = '0;
         acc_reg       = ACCEL_AT_RESET;
         vmax_reg      = VMAX_AT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCELERATION: acc_reg = csr_data;
               CSR_MAX_SPEED:    vmax_reg = csr_data;
               default: ;
            endcase
            csr_writes++;
         end
         // the response, if any, belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               note_mismatch("response with no request outstanding", 0, 1);
            end else begin
               want = pending_results.pop_front();
               if (rsp_commanded_position !== want.position)
                  note_mismatch("commanded_position", $signed(want.position),
                                $signed(rsp_commanded_position));
               if (rsp_profile_velocity !== want.velocity)
                  note_mismatch("profile_velocity", $signed(want.velocity),
                                $signed(rsp_profile_velocity));
               if (rsp_homing_active !== want.homing)
                  note_mismatch("homing_active", want.homing, rsp_homing_active);
               if (rsp_sensor_reset !== want.sensor_reset)
                  note_mismatch("sensor_reset", want.sensor_reset, rsp_sensor_reset);
            end
            responses_seen++;
         end
         if (req_valid && req_ready) begin
            seen.command   = req_command;
            seen.elapsed   = req_elapsed_time;
            seen.target    = req_target_position;
            seen.measured  = req_measured_position;
            seen.rev_limit = req_reverse_limit;
            want = step_profiler(seen);
            if (seen.command == CMD_HOME) home_commands++;
            if (want.sensor_reset) homing_completions++;
            pending_results.push_back(want);
            req_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------
   // request driver: falling edge, holds the payload until accepted
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted == req_issued) begin
         if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_item = tick_queue.pop_front();
            req_command           <= drive_item.command;
            req_elapsed_time      <= drive_item.elapsed;
            req_target_position   <= drive_item.target;
            req_measured_position <= drive_item.measured;
            req_reverse_limit     <= drive_item.rev_limit;
            req_valid             <= 1'b1;
            req_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // response sink: random stalls plus one long hold-off so the block backs up
   // ------------------------------------------------------------------
   int hold_left = 0;
   bit long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!long_hold_done && responses_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("[trapezoidal_position_profiler_top] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_tick(input logic cmd, input logic [RW-1:0] elapsed,
                            input logic [W-1:0] target, input logic [W-1:0] measured,
                            input logic lim);
      tick_request_type rq;
      rq.command   = cmd;
      rq.elapsed   = elapsed;
      rq.target    = target;
      rq.measured  = measured;
      rq.rev_limit = lim;
      tick_queue.push_back(rq);
      items_generated++;
   endtask

   function automatic logic [RW-1:0] pick_elapsed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return RW'($urandom);                           // any value, clamped
         2:       return RW'(DT_CLAMP) + RW'($urandom_range(0, 2)) - RW'(1);
         default: return RW'($urandom_range(1000, 900000));
      endcase
   endfunction

   // mostly near zero so motion settles, sometimes the word extremes
   function automatic logic [W-1:0] pick_position();
      case ($urandom_range(0, 7))
         0:       return W'(WORD_HI);
         1:       return W'(WORD_LO);
         2, 3:    return W'($urandom);
         default: return W'($urandom_range(0, 32'h0800_0000)) - W'(32'h0400_0000);
      endcase
   endfunction

   task automatic gen_profile_run(input int n);
      logic [W-1:0] target;
      target = pick_position();
      for (int i = 0; i < n; i++) begin
         // occasionally move the goal mid run
         if ($urandom_range(0, 9) == 0) target = pick_position();
         push_tick(CMD_TICK, pick_elapsed(), target, W'($urandom), 1'($urandom));
      end
   endtask

   // home command then homing ticks with the sensor tracking the downward steps
   task automatic gen_homing_run(input int n, input bit allow_limit);
      longint base;
      longint meas;
      longint jitter;
      logic   lim;
      base = $signed(pick_position());
      push_tick(CMD_HOME, RW'($urandom), W'($urandom), W'($urandom), 1'($urandom));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) jitter = $signed(W'($urandom));
         else jitter = longint'($urandom_range(0, 600000)) - 300000;
         meas = word_sat(base - longint'(k) * HOME_DROP + jitter);
         lim  = allow_limit && ((k == n - 1 && $urandom_range(0, 3) != 0) ||
                                $urandom_range(0, 29) == 0);
         if (allow_limit && $urandom_range(0, 19) == 0)
            push_tick(CMD_HOME, RW'($urandom), W'($urandom), W'(meas), 1'b0);
         push_tick(CMD_TICK, RW'($urandom), W'($urandom), W'(meas), lim);
      end
   endtask

   task automatic gen_random(input int n, input bit long_homing);
      int stop_at;
      int pick;
      stop_at = items_generated + n;
      // one homing run that runs past the step limit
      if (long_homing) gen_homing_run(103, 1'b0);
      while (items_generated < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            gen_profile_run($urandom_range(3, 20));
         end else if (pick < 85) begin
            gen_homing_run($urandom_range(1, 14), 1'b1);
         end else begin
            // noise: fully random fields
            repeat ($urandom_range(1, 3))
               push_tick(1'($urandom), RW'($urandom), W'($urandom), W'($urandom),
                         1'($urandom));
         end
      end
   endtask

   task automatic wait_until_drained();
      while (!(tick_queue.size() == 0 && req_accepted == req_issued &&
               pending_results.size() == 0)) @(posedge clock);
   endtask

   // one write, held for exactly one accepting edge
   task automatic write_register(input logic [IW-1:0] index, input logic [RW-1:0] value);
      @(negedge clock);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drain, settle, then load new registers and idle pattern and run a batch
   task automatic run_phase(input logic [RW-1:0] accel, input logic [RW-1:0] vmax,
                            input int send_idle, input int recv_stall, input int n,
                            input bit long_homing);
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(CSR_ACCELERATION, accel);
      write_register(CSR_MAX_SPEED, vmax);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
      gen_random(n, long_homing);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   int settings_used = 1;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part with the reset register values
      send_idle_pct  = 11;
      recv_stall_pct = 78;
      // full clamp of elapsed time, accelerate toward the top of the range
      push_tick(CMD_TICK, REG_TOP, W'(WORD_HI), '0, 1'b0);
      push_tick(CMD_TICK, REG_TOP, W'(WORD_HI), W'(WORD_LO), 1'b1);
      push_tick(CMD_TICK, REG_TOP, W'(WORD_HI), '1, 1'b0);
      // zero elapsed time
      push_tick(CMD_TICK, '0, W'(WORD_HI), '0, 1'b0);
      // moving away from the target, brake, around the clamp value
      push_tick(CMD_TICK, RW'(DT_CLAMP), W'(WORD_LO), '0, 1'b0);
      push_tick(CMD_TICK, RW'(DT_CLAMP) - RW'(1), W'(WORD_LO), '0, 1'b0);
      push_tick(CMD_TICK, RW'(DT_CLAMP) + RW'(1), W'(WORD_LO), '0, 1'b0);
      // settle back to zero, stopping distance decides
      push_tick(CMD_TICK, RW'(DT_CLAMP), '0, '0, 1'b0);
      push_tick(CMD_TICK, RW'(DT_CLAMP), '0, '0, 1'b0);
      push_tick(CMD_TICK, RW'(DT_CLAMP), '0, '0, 1'b0);
      // homing: command ignores the other fields
      push_tick(CMD_HOME, REG_TOP, '1, '1, 1'b1);
      push_tick(CMD_TICK, REG_TOP, '1, W'(WORD_HI), 1'b0);                 // far, snaps
      push_tick(CMD_TICK, '0, '0, W'(WORD_HI - 2 * HOME_DROP), 1'b0);      // close, steps
      push_tick(CMD_HOME, '0, '0, '0, 1'b0);                               // keeps the count
      push_tick(CMD_TICK, '0, '0, W'(WORD_LO), 1'b0);                      // snaps to bottom
      push_tick(CMD_TICK, '0, '0, W'(WORD_LO), 1'b0);                      // step saturates
      push_tick(CMD_TICK, '0, '0, W'(WORD_LO), 1'b1);                      // limit switch
      // back in run mode at zero
      push_tick(CMD_TICK, RW'(DT_CLAMP), '0, '0, 1'b0);
      push_tick(CMD_TICK, RW'(DT_CLAMP), W'(1), '0, 1'b0);
      push_tick(CMD_HOME, '0, '0, '0, 1'b0);
      push_tick(CMD_TICK, '0, '0, '0, 1'b1);                               // finish at once
      push_tick(CMD_TICK, RW'(1), '1, '0, 1'b0);

      // sender sparse gaps, receiver stalls a lot
      run_phase(RW'($urandom_range(32'h0040_0000, 32'h0400_0000)),
                RW'($urandom_range(32'h0010_0000, 32'h0200_0000)), 11, 78, 110, 1'b0);
      // zero acceleration and zero speed limit
      run_phase('0, '0, 11, 78, 15, 1'b0);
      // then the other way round
      run_phase(REG_TOP, REG_TOP, 78, 11, 15, 1'b0);
      run_phase(RW'($urandom_range(1, 32'h0010_0000)),
                RW'($urandom_range(32'h0100_0000, 32'h4000_0000)), 78, 11, 100, 1'b0);
      // no idling at all, any register values, one overlong homing run
      run_phase(RW'($urandom), RW'($urandom), 0, 0, 130, 1'b1);
      settings_used = 6;

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests under %0d register settings, %0d home commands, %0d homing runs finished",
               req_accepted, settings_used, home_commands, homing_completions);
      $display("%0d responses checked, %0d mismatches", responses_seen, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[trapezoidal_position_profiler_top] OK");
      end else begin
         $display("[trapezoidal_position_profiler_top] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/tpp_pkg.sv
sv/tpp_mul.sv
sv/trapezoidal_position_profiler_top.sv
verif/trapezoidal_position_profiler_top_test.sv
